// File: hw/rtl/mdmf_pkg.sv
package mdmf_pkg;

    // Command codes carried in the kind field.
    typedef enum logic [1:0] {
        KIND_CHECK  = 2'd0,
        KIND_SET    = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // Configuration register indexes.
    localparam logic [0:0] REG_GATEWAY_FLOOR = 1'd0;
    localparam logic [0:0] REG_MAX_GAP       = 1'd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TSCAN,
        ST_DECIDE,
        ST_WSCAN,
        ST_WPUSH
    } state_t;

endpackage

// File: hw/rtl/mdmf_cell.sv
// One cell of a rotating chain. Each cell holds one (origin, number) pair and
// hands it to its neighbor every cycle while the chain rotates; the filter applies the
// current command to the pair as it leaves the head cell.
module mdmf_cell
    import mdmf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        shift,
    input  logic        load,
    input  logic [15:0] org_in,
    input  logic [15:0] seq_in,
    input  logic        vld_in,
    output logic [15:0] org_out,
    output logic [15:0] seq_out,
    output logic        vld_out
);

    logic [15:0] org_reg;
    logic [15:0] seq_reg;
    logic        vld_reg;

    // Take the input pair on each rotation step or load.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg <= '0;
            seq_reg <= '0;
            vld_reg <= 1'b0;
        end else if (shift || load) begin
            org_reg <= org_in;
            seq_reg <= seq_in;
            vld_reg <= vld_in;
        end
    end

    assign org_out = org_reg;
    assign seq_out = seq_reg;
    assign vld_out = vld_reg;

endmodule

// File: hw/rtl/mesh_duplicate_message_filter.sv
// An accepted beat runs through the table scan and the decide step, then the window scan and
// the push step, or goes straight to its result when the window scan is skipped.
// Each pass rotates a chain one cell per cycle, and a new beat is taken only after the
// result has left.
// Reset is synchronous and clears every cell, the fill count and the window front, and
// loads the register defaults; no clearing pass is needed.
module mesh_duplicate_message_filter
    import mdmf_pkg::*;
#(
    parameter int TABLE_ENTRIES  = 64,
    parameter int WINDOW_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [15:0] s_origin,
    input  logic [15:0] s_seqnr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_duplicate,
    output logic        m_table_full,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int TW   = $clog2(TABLE_ENTRIES + 1);
    localparam int WI   = $clog2(WINDOW_ENTRIES);
    localparam int CMAX = (TABLE_ENTRIES > WINDOW_ENTRIES) ? TABLE_ENTRIES : WINDOW_ENTRIES;
    localparam int CW   = $clog2(CMAX);

    state_t        state_reg, state_next;
    kind_t         kind_reg;
    logic [15:0]   org_reg, seq_reg, top_reg;
    logic [15:0]   floor_reg, gap_reg;
    logic [TW-1:0] used_reg;
    logic [WI-1:0] front_reg;
    logic [CW-1:0] cnt_reg;
    logic          found_reg, whit_reg, wcheck_reg, push_reg;
    logic          dup_reg, full_reg, out_valid_reg;

    // Table chain: cell 0 is the head, data moves toward lower indexes.
    logic [15:0] t_org [TABLE_ENTRIES];
    logic [15:0] t_seq [TABLE_ENTRIES];
    logic        t_vld [TABLE_ENTRIES];
    logic [15:0] t_org_in [TABLE_ENTRIES];
    logic [15:0] t_seq_in [TABLE_ENTRIES];
    logic        t_vld_in [TABLE_ENTRIES];
    // Window chain: the valid bit marks an occupied slot (nonzero origin).
    logic [15:0] w_org [WINDOW_ENTRIES];
    logic [15:0] w_seq [WINDOW_ENTRIES];
    logic        w_vld [WINDOW_ENTRIES];
    logic [15:0] w_org_in [WINDOW_ENTRIES];
    logic [15:0] w_seq_in [WINDOW_ENTRIES];
    logic        w_vld_in [WINDOW_ENTRIES];

    logic        t_shift, w_shift, t_load, w_load;
    logic [15:0] th_seq;
    logic [15:0] wh_org, wh_seq;
    logic        wh_vld;
    logic        t_match, w_match, w_hit;
    logic        last_t, last_w;
    logic        tbl_full, seq_higher, seq_equal, sure_dup, chk_skip, append;
    logic [16:0] gap_sum;

    // Head of the table chain: edit the pair passing through.
    assign t_match = t_vld[0] && (t_org[0] == org_reg);

    always_comb begin
        th_seq = t_seq[0];
        if (state_reg == ST_TSCAN) begin
            case (kind_reg)
                KIND_CHECK:  if (t_match && (t_seq[0] < seq_reg)) th_seq = seq_reg;
                KIND_SET:    if (t_match) th_seq = seq_reg;
                KIND_DELETE: if (t_match) th_seq = '0;
                KIND_CLEAR:  if (t_vld[0]) th_seq = '0;
                default:     ;
            endcase
        end
    end

    // Head of the window chain: edit the slot passing through.
    assign w_match = (w_org[0] == org_reg);
    assign w_hit   = wcheck_reg ? (w_vld[0] && w_match && (w_seq[0] == seq_reg)) : w_match;

    always_comb begin
        wh_org = w_org[0];
        wh_seq = w_seq[0];
        wh_vld = w_vld[0];
        if (state_reg == ST_WSCAN) begin
            case (kind_reg)
                KIND_CHECK:  if (!wcheck_reg && w_match) wh_seq = seq_reg;
                KIND_SET:    if (w_match) wh_seq = seq_reg;
                KIND_DELETE: if (w_match) begin
                    wh_org = '0;
                    wh_seq = '0;
                    wh_vld = 1'b0;
                end
                KIND_CLEAR: begin
                    wh_org = '0;
                    wh_seq = '0;
                    wh_vld = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Chain wiring: the head's edited pair returns to the tail.
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i == TABLE_ENTRIES - 1) begin
                t_org_in[i] = t_org[0];
                t_seq_in[i] = th_seq;
                t_vld_in[i] = t_vld[0];
            end else begin
                t_org_in[i] = t_org[i+1];
                t_seq_in[i] = t_seq[i+1];
                t_vld_in[i] = t_vld[i+1];
            end
        end
        for (int i = 0; i < WINDOW_ENTRIES; i++) begin
            if (i == WINDOW_ENTRIES - 1) begin
                w_org_in[i] = wh_org;
                w_seq_in[i] = wh_seq;
                w_vld_in[i] = wh_vld;
            end else begin
                w_org_in[i] = w_org[i+1];
                w_seq_in[i] = w_seq[i+1];
                w_vld_in[i] = w_vld[i+1];
            end
        end
    end

    // Cells. An append loads the first free table cell; a push loads the front slot.
    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_tbl
            logic ld;
            assign ld = t_load && (used_reg == TW'(g));
            mdmf_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .shift(t_shift), .load(ld),
                .org_in(ld ? org_reg : t_org_in[g]),
                .seq_in(ld ? seq_reg : t_seq_in[g]),
                .vld_in(ld ? 1'b1 : t_vld_in[g]),
                .org_out(t_org[g]), .seq_out(t_seq[g]), .vld_out(t_vld[g])
            );
        end
        for (g = 0; g < WINDOW_ENTRIES; g++) begin : g_win
            logic ld;
            assign ld = w_load && (front_reg == WI'(g));
            mdmf_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .shift(w_shift), .load(ld),
                .org_in(ld ? org_reg : w_org_in[g]),
                .seq_in(ld ? seq_reg : w_seq_in[g]),
                .vld_in(ld ? (org_reg != '0) : w_vld_in[g]),
                .org_out(w_org[g]), .seq_out(w_seq[g]), .vld_out(w_vld[g])
            );
        end
    endgenerate

    // Pass bookkeeping.
    assign last_t = (cnt_reg == CW'(TABLE_ENTRIES - 1));
    assign last_w = (cnt_reg == CW'(WINDOW_ENTRIES - 1));

    // Decision after the table scan.
    assign gap_sum    = {1'b0, seq_reg} + {1'b0, gap_reg};
    assign tbl_full   = (used_reg == TW'(TABLE_ENTRIES));
    assign seq_higher = (top_reg < seq_reg);
    assign seq_equal  = (top_reg == seq_reg);
    assign sure_dup   = found_reg && !seq_higher && !seq_equal
                        && ((floor_reg < org_reg) || ({1'b0, top_reg} > gap_sum));
    assign chk_skip   = (kind_reg == KIND_CHECK) && ((!found_reg && tbl_full) || sure_dup);
    assign append     = (kind_reg == KIND_CHECK) && !found_reg && !tbl_full;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid && s_ready) state_next = ST_TSCAN;
            ST_TSCAN:  if (last_t) state_next = ST_DECIDE;
            ST_DECIDE: state_next = chk_skip ? ST_IDLE : ST_WSCAN;
            ST_WSCAN:  if (last_w) state_next = ST_WPUSH;
            ST_WPUSH:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Chain control outputs.
    always_comb begin
        t_shift = 1'b0;
        w_shift = 1'b0;
        t_load  = 1'b0;
        w_load  = 1'b0;
        case (state_reg)
            ST_TSCAN:  t_shift = 1'b1;
            ST_DECIDE: t_load  = append;
            ST_WSCAN:  w_shift = 1'b1;
            ST_WPUSH:  w_load  = push_reg;
            default:   ;
        endcase
    end

    // Sequencer registers, configuration and result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_CHECK;
            org_reg       <= '0;
            seq_reg       <= '0;
            top_reg       <= '0;
            used_reg      <= '0;
            front_reg     <= '0;
            cnt_reg       <= '0;
            floor_reg     <= 16'd255;
            gap_reg       <= 16'd64;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            whit_reg      <= 1'b0;
            wcheck_reg    <= 1'b0;
            push_reg      <= 1'b0;
            dup_reg       <= 1'b0;
            full_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && cfg_index == REG_GATEWAY_FLOOR) floor_reg <= cfg_data;
            if (cfg_wr_en && cfg_index == REG_MAX_GAP)       gap_reg <= cfg_data;
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        cnt_reg    <= '0;
                        found_reg  <= 1'b0;
                        whit_reg   <= 1'b0;
                        wcheck_reg <= 1'b0;
                        push_reg   <= 1'b0;
                        dup_reg    <= 1'b0;
                        full_reg   <= 1'b0;
                        kind_reg   <= kind_t'(s_kind);
                        org_reg    <= s_origin;
                        seq_reg    <= s_seqnr;
                    end
                end
                ST_TSCAN: begin
                    // Origins in the table are unique, so at most one entry matches.
                    if (t_match) begin
                        found_reg <= 1'b1;
                        top_reg   <= t_seq[0];
                    end
                    cnt_reg <= last_t ? '0 : cnt_reg + CW'(1);
                end
                ST_DECIDE: begin
                    cnt_reg <= '0;
                    if (append) used_reg <= used_reg + TW'(1);
                    if (kind_reg == KIND_CHECK) begin
                        full_reg   <= !found_reg && tbl_full;
                        dup_reg    <= (found_reg && seq_equal) || sure_dup;
                        wcheck_reg <= found_reg && !seq_higher && !seq_equal && !sure_dup;
                    end
                    if (kind_reg == KIND_CLEAR) front_reg <= '0;
                    if (chk_skip) out_valid_reg <= 1'b1;
                end
                ST_WSCAN: begin
                    if (w_hit) whit_reg <= 1'b1;
                    cnt_reg <= last_w ? '0 : cnt_reg + CW'(1);
                    if (last_w) begin
                        // Push when a set or a check found no matching slot.
                        push_reg <= (kind_reg == KIND_SET || kind_reg == KIND_CHECK)
                                    && !(whit_reg || w_hit);
                        if (wcheck_reg) dup_reg <= whit_reg || w_hit;
                    end
                end
                ST_WPUSH: begin
                    if (push_reg)
                        front_reg <= (front_reg == WI'(WINDOW_ENTRIES - 1)) ? '0
                                                                            : front_reg + WI'(1);
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid      = out_valid_reg;
    assign m_duplicate  = dup_reg;
    assign m_table_full = full_reg;

endmodule

// File: hw/rtl/mdmf_checker.sv
// Port-level checks for the duplicate filter.
module mdmf_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_duplicate,
    input logic m_table_full
);

    // A full table never reports a duplicate.
    a_full_nodup: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_duplicate && m_table_full)) else $error("full and duplicate");

    // No new item is taken while a result waits.
    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken during result");

    // A stalled result stays valid and holds its duplicate flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_duplicate)) else $error("result dropped");

    // Accepting an item drops ready in the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready stayed high");

endmodule

bind mesh_duplicate_message_filter mdmf_checker u_mdmf_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_duplicate(m_duplicate),
    .m_table_full(m_table_full)
);

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mdmf_pkg::*;

    localparam int TBL_N = 64;
    localparam int WIN_N = 64;

    // Predicts the filter decision for each accepted beat and checks results in order.
    class dup_scoreboard;
        logic [15:0] gw_floor;
        logic [15:0] seq_gap;
        logic [15:0] org_tab [TBL_N];
        logic [15:0] top_tab [TBL_N];
        int unsigned n_used;
        logic [15:0] win_org [WIN_N];
        logic [15:0] win_seq [WIN_N];
        int unsigned win_head;
        logic [1:0] pending_q [$];
        int errors;

        function void reset_state();
            gw_floor = 16'd255;
            seq_gap = 16'd64;
            n_used = 0;
            win_head = 0;
            errors = 0;
            pending_q.delete();
            for (int i = 0; i < TBL_N; i++) begin
                org_tab[i] = '0;
                top_tab[i] = '0;
            end
            for (int i = 0; i < WIN_N; i++) begin
                win_org[i] = '0;
                win_seq[i] = '0;
            end
        endfunction

        function void push_pair(logic [15:0] o, logic [15:0] s);
            win_org[win_head] = o;
            win_seq[win_head] = s;
            win_head = (win_head + 1) % WIN_N;
        endfunction

        // Updates every window slot of this origin, or pushes a new pair.
        function void win_update(logic [15:0] o, logic [15:0] s);
            bit hit;
            hit = 0;
            for (int i = 0; i < WIN_N; i++) begin
                if (win_org[i] == o) begin
                    win_seq[i] = s;
                    hit = 1;
                end
            end
            if (!hit) push_pair(o, s);
        endfunction

        function void note_beat(kind_t k, logic [15:0] o, logic [15:0] s);
            bit dup;
            bit full;
            bit found;
            int pos;
            logic [15:0] top;
            dup = 0;
            full = 0;
            found = 0;
            pos = 0;
            case (k)
                KIND_CHECK: begin
                    for (int i = 0; i < n_used; i++) begin
                        if (org_tab[i] == o) begin
                            pos = i;
                            found = 1;
                        end
                    end
                    if (!found) begin
                        if (n_used >= TBL_N) begin
                            full = 1;
                        end else begin
                            org_tab[n_used] = o;
                            top_tab[n_used] = s;
                            n_used++;
                            win_update(o, s);
                        end
                    end else begin
                        top = top_tab[pos];
                        if (top < s) begin
                            top_tab[pos] = s;
                            win_update(o, s);
                        end else if (top == s) begin
                            win_update(o, s);
                            dup = 1;
                        end else if (gw_floor < o) begin
                            dup = 1;
                        end else if ({1'b0, s} + {1'b0, seq_gap} < {1'b0, top}) begin
                            dup = 1;
                        end else begin
                            // Lower number inside the gap: the window decides.
                            for (int i = 0; i < WIN_N; i++) begin
                                if (win_org[i] != 0 && win_org[i] == o && win_seq[i] == s)
                                    dup = 1;
                            end
                            if (!dup) push_pair(o, s);
                        end
                    end
                end
                KIND_SET: begin
                    for (int i = 0; i < n_used; i++)
                        if (org_tab[i] == o) top_tab[i] = s;
                    win_update(o, s);
                end
                KIND_DELETE: begin
                    for (int i = 0; i < n_used; i++)
                        if (org_tab[i] == o) top_tab[i] = '0;
                    for (int i = 0; i < WIN_N; i++) begin
                        if (win_org[i] == o) begin
                            win_org[i] = '0;
                            win_seq[i] = '0;
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < n_used; i++) top_tab[i] = '0;
                    for (int i = 0; i < WIN_N; i++) begin
                        win_org[i] = '0;
                        win_seq[i] = '0;
                    end
                    win_head = 0;
                end
            endcase
            pending_q.push_back({dup, full});
        endfunction

        function void check_result(logic d, logic f);
            logic [1:0] exp_v;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result duplicate=%0b table_full=%0b", $time, d, f);
                errors++;
                return;
            end
            exp_v = pending_q.pop_front();
            if (d !== exp_v[1]) begin
                $display("%0t: duplicate mismatch expected %0b actual %0b", $time, exp_v[1], d);
                errors++;
            end
            if (f !== exp_v[0]) begin
                $display("%0t: table_full mismatch expected %0b actual %0b",
                         $time, exp_v[0], f);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [15:0] s_origin;
    logic [15:0] s_seqnr;
    logic        m_valid;
    logic        m_ready;
    logic        m_duplicate;
    logic        m_table_full;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    dup_scoreboard filter_sb;
    bit rx_stall_on;
    int burst_left;

    mesh_duplicate_message_filter dut (.*);

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Sample both handshakes at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                filter_sb.note_beat(kind_t'(s_kind), s_origin, s_seqnr);
            if (m_valid && m_ready)
                filter_sb.check_result(m_duplicate, m_table_full);
        end
    end

    // Receiver stall pattern: sometimes always ready, sometimes random.
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) rx_stall_on = ~rx_stall_on;
        m_ready <= rx_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // Valid stays high inside a burst; it drops only before a gap or a drain.
    task automatic send_beat(kind_t k, logic [15:0] o, logic [15:0] s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 150);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_kind <= k;
        s_origin <= o;
        s_seqnr <= s;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (filter_sb.pending_q.size() != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_GATEWAY_FLOOR) filter_sb.gw_floor = val;
        else filter_sb.seq_gap = val;
    endtask

    // Mostly a small set of origins so that repeats and window hits are common.
    task automatic random_phase(int count, int n_org);
        logic [15:0] o;
        logic [15:0] s;
        kind_t k;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80) k = KIND_CHECK;
            else if (r < 90) k = KIND_SET;
            else if (r < 98) k = KIND_DELETE;
            else k = KIND_CLEAR;
            if ($urandom_range(0, 9) == 0) o = 16'($urandom);
            else o = 16'($urandom_range(0, n_org) * 16'h0111);
            if ($urandom_range(0, 9) == 0) s = 16'($urandom);
            else s = 16'(16'd1000 + $urandom_range(0, 120));
            send_beat(k, o, s);
        end
    endtask

    initial begin
        filter_sb = new();
        filter_sb.reset_state();
        rx_stall_on = 1'b0;
        burst_left = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = '0;
        s_origin = '0;
        s_seqnr = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: new origin, higher, equal, lower inside and outside gap, window hit.
        send_beat(KIND_CHECK, 16'd5, 16'd100);
        send_beat(KIND_CHECK, 16'd5, 16'd200);
        send_beat(KIND_CHECK, 16'd5, 16'd200);
        send_beat(KIND_CHECK, 16'd5, 16'd150);
        send_beat(KIND_CHECK, 16'd5, 16'd150);
        send_beat(KIND_CHECK, 16'd5, 16'd10);
        send_beat(KIND_CHECK, 16'hFFFF, 16'hFFFF);
        send_beat(KIND_CHECK, 16'hFFFF, 16'd0);
        send_beat(KIND_CHECK, 16'd0, 16'd7);
        send_beat(KIND_CHECK, 16'd0, 16'd3);
        send_beat(KIND_CHECK, 16'd0, 16'd3);
        send_beat(KIND_SET, 16'd5, 16'd40);
        send_beat(KIND_SET, 16'd777, 16'd9);
        send_beat(KIND_DELETE, 16'd5, 16'd0);
        send_beat(KIND_CHECK, 16'd5, 16'd0);
        send_beat(KIND_DELETE, 16'd0, 16'hFFFF);
        send_beat(KIND_CLEAR, 16'hAAAA, 16'h5555);
        send_beat(KIND_CHECK, 16'd5, 16'd1);
        // Sender holds off until every result has come back.
        wait_drained();

        // Fill the table to overflow, then extreme register settings.
        for (int i = 0; i < 66; i++) send_beat(KIND_CHECK, 16'(300 + i), 16'(i));
        wait_drained();
        write_reg(REG_GATEWAY_FLOOR, 16'hFFFF);
        write_reg(REG_MAX_GAP, 16'hFFFF);
        send_beat(KIND_CHECK, 16'd300, 16'd0);
        send_beat(KIND_CHECK, 16'd301, 16'd0);
        send_beat(KIND_CHECK, 16'd301, 16'd0);
        wait_drained();

        // Random phases over several register settings; no reset is applied between them,
        // so each phase lives with the full table, which still exercises known origins.
        write_reg(REG_GATEWAY_FLOOR, 16'd0);
        write_reg(REG_MAX_GAP, 16'd0);
        random_phase(400, 12);
        wait_drained();
        write_reg(REG_GATEWAY_FLOOR, 16'h8000);
        write_reg(REG_MAX_GAP, 16'd40);
        random_phase(400, 12);
        wait_drained();
        write_reg(REG_GATEWAY_FLOOR, 16'hFFFF);
        write_reg(REG_MAX_GAP, 16'd64);
        random_phase(450, 12);
        wait_drained();
        write_reg(REG_GATEWAY_FLOOR, 16'($urandom));
        write_reg(REG_MAX_GAP, 16'($urandom_range(0, 200)));
        random_phase(400, 12);
        wait_drained();

        if (filter_sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("tb failed");
        $finish;
    end

endmodule
